// ===== rtl/core/gsbi_pkg.sv =====
// Package with grid geometry, bank layout, field types and fixed-point constants.
`timescale 1ns / 1ps
package gsbi_pkg;

  // Grid geometry; points are spaced one metre apart.
  localparam int GRID_COLS = 701;
  localparam int GRID_ROWS = 1251;
  localparam int CELL_MM   = 1000;

  // Field widths set by the item layout.
  localparam int COORD_W = 32;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 11;
  localparam int VAL_W   = 18;
  localparam int FLAG_W  = 4;
  localparam int FRAC_W  = 10;   // offset inside a cell, 0 to 999
  localparam int WGT_W   = 20;   // corner weight, up to 10^6

  // The grid is split over four banks by row and column parity, so the four
  // corners of any cell sit in four different banks.
  localparam int BANK_COLS  = (GRID_COLS + 1) / 2;
  localparam int BANK_ROWS  = (GRID_ROWS + 1) / 2;
  localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Item codes.
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_SHIFT = 2'd1;
  localparam mode_t MODE_GEOID = 2'd2;

  // One stored grid point.
  typedef struct packed {
    logic signed [VAL_W-1:0]  east;
    logic signed [VAL_W-1:0]  north;
    logic signed [VAL_W-1:0]  geoid;
    logic        [FLAG_W-1:0] flag;
  } point_t;

  // floor(x / 1000) = (x * DIV1K_MUL) >> DIV1K_SHIFT for any x below 2^31.
  localparam int DIV1K_MW    = 29;
  localparam int DIV1K_SHIFT = 38;
  localparam logic [DIV1K_MW-1:0] DIV1K_MUL = 29'd274877907;
  localparam int QUO_W = COORD_W - 1 + DIV1K_MW;

  // Blend rounding: the sum is biased so it is never negative, then divided
  // by 10^6 as a shift by 6 and a reciprocal multiply for 15625.
  localparam int SUM_W = 38;
  localparam logic [SUM_W-1:0] ROUND_BIAS = 38'd131072500000;
  localparam int DIVM_SHIFT = 45;
  localparam logic [31:0] DIVM_MUL = 32'd2251799814;

endpackage

// ===== rtl/core/grid_shift_bilinear_interpolator.sv =====
// Top level of the grid shift bilinear interpolator: banked grid store and pipeline.
// Throughput: one beat per cycle while out_stall is low; loads and queries can be
// freely interleaved. A result passes through nine register stages after its input
// beat is accepted; any stage that holds a bubble absorbs a stall.
// Reset: rst_n is synchronous and active low; it clears the stage valid bits only.
// The grid banks are not cleared; a point is undefined until it is loaded.
`timescale 1ns / 1ps
module grid_shift_bilinear_interpolator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_mode,
  input  logic signed [gsbi_pkg::COORD_W-1:0]    in_easting_mm,
  input  logic signed [gsbi_pkg::COORD_W-1:0]    in_northing_mm,
  input  logic                                   in_newlyn_only,
  input  logic [gsbi_pkg::COL_W-1:0]             in_load_col,
  input  logic [gsbi_pkg::ROW_W-1:0]             in_load_row,
  input  logic signed [gsbi_pkg::VAL_W-1:0]      in_load_east_shift,
  input  logic signed [gsbi_pkg::VAL_W-1:0]      in_load_north_shift,
  input  logic signed [gsbi_pkg::VAL_W-1:0]      in_load_geoid,
  input  logic [gsbi_pkg::FLAG_W-1:0]            in_load_flag,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_ok,
  output logic signed [gsbi_pkg::COORD_W-1:0]    out_east_out_mm,
  output logic signed [gsbi_pkg::COORD_W-1:0]    out_north_out_mm,
  output logic signed [gsbi_pkg::VAL_W-1:0]      out_height_corr_mm
);
  import gsbi_pkg::*;

  // Stage valid bits and per-stage advance enables. A stage loads when it is
  // empty or when the stage after it loads, so bubbles are squeezed out and
  // an input beat is taken while a result waits at the output if a stage is empty.
  logic [9:1] valid_r;
  logic [9:1] en;

  always_comb begin
    en[9] = !valid_r[9] || !out_stall;
    for (int k = 8; k >= 1; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[1];
  assign out_valid = valid_r[9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[1]) begin
        valid_r[1] <= in_valid;
      end
      for (int k = 2; k <= 9; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Stage 1: input register.
  mode_t                      s1_mode_r;
  logic signed [COORD_W-1:0]  s1_e_r, s1_n_r;
  logic                       s1_newlyn_r;
  point_t                     s1_pt_r;
  logic [COL_W-1:0]           s1_col_r;
  logic [ROW_W-1:0]           s1_row_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_mode_r   <= in_mode;
      s1_e_r      <= in_easting_mm;
      s1_n_r      <= in_northing_mm;
      s1_newlyn_r <= in_newlyn_only;
      s1_pt_r     <= '{east: in_load_east_shift, north: in_load_north_shift,
                       geoid: in_load_geoid, flag: in_load_flag};
      s1_col_r    <= in_load_col;
      s1_row_r    <= in_load_row;
    end
  end

  // Stage 2: reciprocal multiply for the division by the cell size. Negative
  // coordinates are rejected later, so only the low 31 bits matter here.
  mode_t                      s2_mode_r;
  logic signed [COORD_W-1:0]  s2_e_r, s2_n_r;
  logic                       s2_newlyn_r;
  point_t                     s2_pt_r;
  logic [COL_W-1:0]           s2_col_r;
  logic [ROW_W-1:0]           s2_row_r;
  logic [QUO_W-1:0]           s2_qe_r, s2_qn_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_mode_r   <= s1_mode_r;
      s2_e_r      <= s1_e_r;
      s2_n_r      <= s1_n_r;
      s2_newlyn_r <= s1_newlyn_r;
      s2_pt_r     <= s1_pt_r;
      s2_col_r    <= s1_col_r;
      s2_row_r    <= s1_row_r;
      s2_qe_r     <= QUO_W'(s1_e_r[COORD_W-2:0]) * QUO_W'(DIV1K_MUL);
      s2_qn_r     <= QUO_W'(s1_n_r[COORD_W-2:0]) * QUO_W'(DIV1K_MUL);
    end
  end

  // Stage 3: cell indices, offsets inside the cell and the range check.
  localparam int CIDX_W = QUO_W - DIV1K_SHIFT;

  logic [CIDX_W-1:0]  e0_full, n0_full;
  logic [COORD_W-1:0] e_rem, n_rem;
  logic               q_in_grid;

  always_comb begin
    e0_full   = s2_qe_r[QUO_W-1:DIV1K_SHIFT];
    n0_full   = s2_qn_r[QUO_W-1:DIV1K_SHIFT];
    e_rem     = COORD_W'(s2_e_r) - COORD_W'(COORD_W'(e0_full) * COORD_W'(CELL_MM));
    n_rem     = COORD_W'(s2_n_r) - COORD_W'(COORD_W'(n0_full) * COORD_W'(CELL_MM));
    q_in_grid = !s2_e_r[COORD_W-1] && !s2_n_r[COORD_W-1] &&
                (e0_full < CIDX_W'(GRID_COLS - 1)) && (n0_full < CIDX_W'(GRID_ROWS - 1));
  end

  mode_t                      s3_mode_r;
  logic signed [COORD_W-1:0]  s3_e_r, s3_n_r;
  logic                       s3_newlyn_r;
  point_t                     s3_pt_r;
  logic [COL_W-1:0]           s3_col_r;
  logic [ROW_W-1:0]           s3_row_r;
  logic                       s3_qok_r;
  logic [COL_W-1:0]           s3_e0_r;
  logic [ROW_W-1:0]           s3_n0_r;
  logic [FRAC_W-1:0]          s3_de_r, s3_dn_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_mode_r   <= s2_mode_r;
      s3_e_r      <= s2_e_r;
      s3_n_r      <= s2_n_r;
      s3_newlyn_r <= s2_newlyn_r;
      s3_pt_r     <= s2_pt_r;
      s3_col_r    <= s2_col_r;
      s3_row_r    <= s2_row_r;
      s3_qok_r    <= q_in_grid;
      s3_e0_r     <= e0_full[COL_W-1:0];
      s3_n0_r     <= n0_full[ROW_W-1:0];
      s3_de_r     <= e_rem[FRAC_W-1:0];
      s3_dn_r     <= n_rem[FRAC_W-1:0];
    end
  end

  // Stage 4: bank addresses, bank write selects and the four corner weights.
  // Within a bank, a point lives at (row / 2) * BANK_COLS + col / 2. For a cell
  // with corner column e0, the even bank holds column (e0 + 1) / 2 and the odd
  // bank column e0 / 2; rows work the same way.
  logic [BANK_AW-1:0] q_addr [4];
  logic [BANK_AW-1:0] ld_addr;
  logic [1:0]         ld_bank;
  logic               ld_in_grid;
  logic [COL_W-1:0]   colh_even, colh_odd;
  logic [ROW_W-1:0]   rowh_even, rowh_odd;
  logic [FRAC_W-1:0]  de_inv, dn_inv;
  logic               s4_ok_nxt;

  always_comb begin
    colh_even = COL_W'((COL_W'(s3_e0_r) + COL_W'(1)) >> 1);
    colh_odd  = s3_e0_r >> 1;
    rowh_even = ROW_W'((ROW_W'(s3_n0_r) + ROW_W'(1)) >> 1);
    rowh_odd  = s3_n0_r >> 1;
    for (int b = 0; b < 4; b++) begin
      q_addr[b] = BANK_AW'(BANK_AW'(b[1] ? rowh_odd : rowh_even) * BANK_AW'(BANK_COLS)
                  + BANK_AW'(b[0] ? colh_odd : colh_even));
    end
    ld_addr    = BANK_AW'(BANK_AW'(s3_row_r >> 1) * BANK_AW'(BANK_COLS)
                 + BANK_AW'(s3_col_r >> 1));
    ld_bank    = {s3_row_r[0], s3_col_r[0]};
    ld_in_grid = (s3_col_r < COL_W'(GRID_COLS)) && (s3_row_r < ROW_W'(GRID_ROWS));
    de_inv     = FRAC_W'(CELL_MM) - s3_de_r;
    dn_inv     = FRAC_W'(CELL_MM) - s3_dn_r;
    unique case (s3_mode_r)
      MODE_LOAD:               s4_ok_nxt = ld_in_grid;
      MODE_SHIFT, MODE_GEOID:  s4_ok_nxt = s3_qok_r;
      default:                 s4_ok_nxt = 1'b0;
    endcase
  end

  mode_t                      s4_mode_r;
  logic signed [COORD_W-1:0]  s4_e_r, s4_n_r;
  logic                       s4_newlyn_r;
  point_t                     s4_pt_r;
  logic                       s4_ok_r;
  logic [BANK_AW-1:0]         s4_addr_r [4];
  logic [3:0]                 s4_wr_r;
  logic                       s4_rd_r;
  logic                       s4_ep_r, s4_np_r;
  logic [WGT_W-1:0]           s4_w_r [4];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_mode_r   <= s3_mode_r;
      s4_e_r      <= s3_e_r;
      s4_n_r      <= s3_n_r;
      s4_newlyn_r <= s3_newlyn_r;
      s4_pt_r     <= s3_pt_r;
      s4_ok_r     <= s4_ok_nxt;
      s4_ep_r     <= s3_e0_r[0];
      s4_np_r     <= s3_n0_r[0];
      s4_rd_r     <= (s3_mode_r == MODE_SHIFT || s3_mode_r == MODE_GEOID) && s3_qok_r;
      for (int b = 0; b < 4; b++) begin
        s4_wr_r[b]   <= (s3_mode_r == MODE_LOAD) && ld_in_grid && (ld_bank == 2'(b));
        s4_addr_r[b] <= (s3_mode_r == MODE_LOAD) ? ld_addr : q_addr[b];
      end
      s4_w_r[0] <= WGT_W'(de_inv) * WGT_W'(dn_inv);
      s4_w_r[1] <= WGT_W'(s3_de_r) * WGT_W'(dn_inv);
      s4_w_r[2] <= WGT_W'(de_inv) * WGT_W'(s3_dn_r);
      s4_w_r[3] <= WGT_W'(s3_de_r) * WGT_W'(s3_dn_r);
    end
  end

  // Stage 5: grid banks. Every item in this stage touches each bank at most
  // once, either a load write or a corner read, so single-port banks serve
  // one beat per cycle. A load written here is seen by the next query.
  logic [3:0] bank_wr_go, bank_rd_go;
  point_t     bank_rd_r [4];

  assign bank_wr_go = (en[5] && valid_r[4]) ? s4_wr_r : 4'b0;
  assign bank_rd_go = (en[5] && valid_r[4] && s4_rd_r) ? 4'b1111 : 4'b0;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    point_t grid_mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (bank_wr_go[b]) begin
        grid_mem[s4_addr_r[b]] <= s4_pt_r;
      end
      if (bank_rd_go[b]) begin
        bank_rd_r[b] <= grid_mem[s4_addr_r[b]];
      end
    end
  end

  mode_t                      s5_mode_r;
  logic signed [COORD_W-1:0]  s5_e_r, s5_n_r;
  logic                       s5_newlyn_r;
  logic                       s5_ok_r;
  logic                       s5_ep_r, s5_np_r;
  logic [WGT_W-1:0]           s5_w_r [4];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_mode_r   <= s4_mode_r;
      s5_e_r      <= s4_e_r;
      s5_n_r      <= s4_n_r;
      s5_newlyn_r <= s4_newlyn_r;
      s5_ok_r     <= s4_ok_r;
      s5_ep_r     <= s4_ep_r;
      s5_np_r     <= s4_np_r;
      s5_w_r      <= s4_w_r;
    end
  end

  // Stage 6: route bank data to corners, check flags, weight each corner.
  localparam int PROD_W = WGT_W + 1 + VAL_W;

  point_t corner [4];
  logic   flags_good;
  logic   strict_flag;

  always_comb begin
    strict_flag = (s5_mode_r == MODE_GEOID) && s5_newlyn_r;
    flags_good  = 1'b1;
    for (int k = 0; k < 4; k++) begin
      corner[k] = bank_rd_r[{s5_np_r ^ k[1], s5_ep_r ^ k[0]}];
      if (strict_flag) begin
        if (corner[k].flag != FLAG_W'(1)) flags_good = 1'b0;
      end else if (corner[k].flag == '0) begin
        flags_good = 1'b0;
      end
    end
  end

  mode_t                      s6_mode_r;
  logic signed [COORD_W-1:0]  s6_e_r, s6_n_r;
  logic                       s6_ok_r;
  logic signed [PROD_W-1:0]   s6_pe_r [4];
  logic signed [PROD_W-1:0]   s6_pn_r [4];
  logic signed [PROD_W-1:0]   s6_pg_r [4];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_mode_r <= s5_mode_r;
      s6_e_r    <= s5_e_r;
      s6_n_r    <= s5_n_r;
      s6_ok_r   <= s5_ok_r && ((s5_mode_r == MODE_LOAD) || flags_good);
      for (int k = 0; k < 4; k++) begin
        s6_pe_r[k] <= PROD_W'($signed({1'b0, s5_w_r[k]}) * corner[k].east);
        s6_pn_r[k] <= PROD_W'($signed({1'b0, s5_w_r[k]}) * corner[k].north);
        s6_pg_r[k] <= PROD_W'($signed({1'b0, s5_w_r[k]}) * corner[k].geoid);
      end
    end
  end

  // Stage 7: add the weighted corners plus rounding and bias, divide by 64.
  localparam int ACC_W = SUM_W + 2;

  logic signed [ACC_W-1:0] acc_e, acc_n, acc_g;

  always_comb begin
    acc_e = ACC_W'(s6_pe_r[0]) + ACC_W'(s6_pe_r[1]) + ACC_W'(s6_pe_r[2])
          + ACC_W'(s6_pe_r[3]) + $signed(ACC_W'(ROUND_BIAS));
    acc_n = ACC_W'(s6_pn_r[0]) + ACC_W'(s6_pn_r[1]) + ACC_W'(s6_pn_r[2])
          + ACC_W'(s6_pn_r[3]) + $signed(ACC_W'(ROUND_BIAS));
    acc_g = ACC_W'(s6_pg_r[0]) + ACC_W'(s6_pg_r[1]) + ACC_W'(s6_pg_r[2])
          + ACC_W'(s6_pg_r[3]) + $signed(ACC_W'(ROUND_BIAS));
  end

  mode_t                      s7_mode_r;
  logic signed [COORD_W-1:0]  s7_e_r, s7_n_r;
  logic                       s7_ok_r;
  logic [31:0]                s7_xe_r, s7_xn_r, s7_xg_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_mode_r <= s6_mode_r;
      s7_e_r    <= s6_e_r;
      s7_n_r    <= s6_n_r;
      s7_ok_r   <= s6_ok_r;
      s7_xe_r   <= acc_e[SUM_W-1:6];
      s7_xn_r   <= acc_n[SUM_W-1:6];
      s7_xg_r   <= acc_g[SUM_W-1:6];
    end
  end

  // Stage 8: divide by 15625 through a reciprocal multiply. The quotient is
  // the blended value plus the bias of 2^17, so it always fits in 18 bits.
  logic [63:0] me, mn, mg;

  assign me = 64'(s7_xe_r) * 64'(DIVM_MUL);
  assign mn = 64'(s7_xn_r) * 64'(DIVM_MUL);
  assign mg = 64'(s7_xg_r) * 64'(DIVM_MUL);

  mode_t                      s8_mode_r;
  logic signed [COORD_W-1:0]  s8_e_r, s8_n_r;
  logic                       s8_ok_r;
  logic [VAL_W-1:0]           s8_qe_r, s8_qn_r, s8_qg_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_mode_r <= s7_mode_r;
      s8_e_r    <= s7_e_r;
      s8_n_r    <= s7_n_r;
      s8_ok_r   <= s7_ok_r;
      s8_qe_r   <= me[DIVM_SHIFT+VAL_W-1:DIVM_SHIFT];
      s8_qn_r   <= mn[DIVM_SHIFT+VAL_W-1:DIVM_SHIFT];
      s8_qg_r   <= mg[DIVM_SHIFT+VAL_W-1:DIVM_SHIFT];
    end
  end

  // Stage 9: remove the bias, apply the shifts and register the result.
  // Fields that do not apply to the item, or to a rejected item, read zero.
  logic signed [VAL_W-1:0] blend_e, blend_n, blend_g;

  assign blend_e = $signed(s8_qe_r - VAL_W'(1 << (VAL_W - 1)));
  assign blend_n = $signed(s8_qn_r - VAL_W'(1 << (VAL_W - 1)));
  assign blend_g = $signed(s8_qg_r - VAL_W'(1 << (VAL_W - 1)));

  always_ff @(posedge clk) begin
    if (en[9]) begin
      out_ok <= s8_ok_r;
      if (s8_ok_r && s8_mode_r == MODE_SHIFT) begin
        out_east_out_mm  <= s8_e_r + COORD_W'(blend_e);
        out_north_out_mm <= s8_n_r + COORD_W'(blend_n);
      end else begin
        out_east_out_mm  <= '0;
        out_north_out_mm <= '0;
      end
      out_height_corr_mm <= (s8_ok_r && s8_mode_r == MODE_GEOID) ? blend_g : '0;
    end
  end

`ifndef SYNTHESIS
  a_empty_out_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output register is empty");

  a_reject_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |->
      out_east_out_mm == 0 && out_north_out_mm == 0 && out_height_corr_mm == 0)
    else $error("rejected beat carries nonzero fields");

  a_bank_single_port: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_wr_go & bank_rd_go) == 4'b0)
    else $error("grid bank read and written in the same cycle");

  a_one_write_per_load: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(bank_wr_go) <= 1)
    else $error("load wrote more than one grid bank");
`endif

endmodule
